[hdl/cpq_pkg.sv]
// shared types, widths and operation codes of the coalescing priority task queue
// no dependencies
package cpq_pkg;

  localparam int unsigned OpW   = 3;
  localparam int unsigned TaskW = 5;
  localparam int unsigned PrioW = 8;
  localparam int unsigned PendW = 16;

  localparam int unsigned NumTasksDef   = 32;
  localparam int unsigned MaxRunnersDef = 7;

  localparam logic [PendW-1:0] PendMax = '1;

  // operation codes
  localparam logic [OpW-1:0] OpEnqueue  = 3'd0;
  localparam logic [OpW-1:0] OpDequeue  = 3'd1;
  localparam logic [OpW-1:0] OpCancel   = 3'd2;
  localparam logic [OpW-1:0] OpBlock    = 3'd3;
  localparam logic [OpW-1:0] OpUnblock  = 3'd4;
  localparam logic [OpW-1:0] OpComplete = 3'd5;

  typedef struct packed {
    logic [OpW-1:0]   op;
    logic [TaskW-1:0] task_id;
    logic [PrioW-1:0] priority_req;
  } cpq_in_t;

  typedef struct packed {
    logic             notify;
    logic [TaskW-1:0] task_out;
    logic [PendW-1:0] pending_out;
    logic             empty_res;
    logic             busy_res;
    logic             coalesced;
  } cpq_out_t;

  // one queued entry held by a cell
  typedef struct packed {
    logic             vld;
    logic [TaskW-1:0] id;
    logic [PrioW-1:0] prio;
  } cpq_entry_t;

  // command broadcast to every cell of the chain
  typedef struct packed {
    logic             insert;
    logic             pop;
    logic             remove;
    logic [TaskW-1:0] id;
    logic [PrioW-1:0] prio;
  } cpq_cmd_t;

endpackage

[hdl/coalescing_priority_task_queue.sv]
// top level of the coalescing priority task queue
// depends on cpq_pkg, cpq_chain and cpq_tbl
//
// usage
//   input channel in_valid_i / in_stall_o / in_i carries one operation per
//   transfer: enqueue, dequeue head, cancel, block, unblock, complete
//   output channel out_valid_o / out_stall_i / out_o returns exactly one
//   result per input transfer, in order
// operation flow
//   the accepting edge loads the item and reads the count table; the
//   execute edge, once the result register is free or being emptied,
//   inserts, pops or removes in the queue chain, writes the table and
//   loads the result register; no new item is taken until the current
//   one executes, set by the read-then-write of the per-task count table
// reset
//   queue cells, table valid bits, block, deferred and output valid flags
//   are cleared at once; no clearing pass, items accepted at once
// stall
//   while the receiver stalls a held result, the next item waits in the
//   execute slot and in_stall_o stays high until the result is taken
module coalescing_priority_task_queue #(
  parameter int unsigned NUM_TASKS   = cpq_pkg::NumTasksDef,
  parameter int unsigned MAX_RUNNERS = cpq_pkg::MaxRunnersDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cpq_pkg::cpq_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cpq_pkg::cpq_out_t out_o
);

  localparam int unsigned IdxW = $clog2(NUM_TASKS);
  localparam int unsigned RunW = $clog2(MAX_RUNNERS + 1);
  localparam logic [RunW-1:0] RunMax = RunW'(MAX_RUNNERS);

  // control and item registers
  logic              busy_q;
  cpq_pkg::cpq_in_t  item_q;
  logic [IdxW-1:0]   addr_q;
  logic              blocked_q, blocked_d;
  logic              deferred_q, deferred_d;
  logic              out_valid_q;
  cpq_pkg::cpq_out_t out_q, res;

  logic                      accept, exec, t_ok, wr_en;
  logic [IdxW-1:0]           rd_addr;
  logic [cpq_pkg::PendW-1:0] pend, new_pend;
  logic [RunW-1:0]           run, new_run;
  cpq_pkg::cpq_cmd_t         cmd, cmd_g;
  cpq_pkg::cpq_entry_t       head;

  // a new transfer is taken only while the execute slot is empty
  assign accept     = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;
  // execute once the result register is free or being emptied
  assign exec       = busy_q && (!out_valid_q || !out_stall_i);

  // dequeue looks up the head task, everything else the addressed task
  assign rd_addr = (in_i.op == cpq_pkg::OpDequeue) ? IdxW'(head.id) : IdxW'(in_i.task_id);

  assign t_ok = int'(item_q.task_id) < NUM_TASKS;

  // operation decode for the item in the execute slot
  always_comb begin
    res        = '0;
    cmd        = '0;
    cmd.id     = item_q.task_id;
    cmd.prio   = item_q.priority_req;
    wr_en      = 1'b0;
    new_pend   = pend;
    new_run    = run;
    blocked_d  = blocked_q;
    deferred_d = deferred_q;
    case (item_q.op)
      cpq_pkg::OpEnqueue: begin
        if (t_ok) begin
          wr_en = 1'b1;
          if (pend != '0) begin
            // already queued: only the count rises, saturating
            res.coalesced = 1'b1;
            if (pend != cpq_pkg::PendMax) begin
              new_pend = pend + 1'b1;
            end
          end else begin
            cmd.insert = 1'b1;
            new_pend   = cpq_pkg::PendW'(1);
            if (blocked_q) begin
              deferred_d = 1'b1;
            end else begin
              res.notify = 1'b1;
            end
          end
        end
      end
      cpq_pkg::OpDequeue: begin
        if (head.vld) begin
          res.task_out    = head.id;
          res.pending_out = pend;
          new_pend        = '0;
          if (run != RunMax) begin
            new_run = run + 1'b1;
          end
          cmd.pop = 1'b1;
          wr_en   = 1'b1;
        end else begin
          res.empty_res = 1'b1;
        end
      end
      cpq_pkg::OpCancel: begin
        if (t_ok) begin
          res.pending_out = pend;
          res.busy_res    = (run != '0);
          cmd.remove      = (pend != '0);
          new_pend        = '0;
          wr_en           = 1'b1;
        end
      end
      cpq_pkg::OpBlock: begin
        blocked_d = 1'b1;
      end
      cpq_pkg::OpUnblock: begin
        blocked_d = 1'b0;
        if (deferred_q) begin
          deferred_d = 1'b0;
          res.notify = 1'b1;
        end
      end
      cpq_pkg::OpComplete: begin
        if (t_ok && (run != '0)) begin
          new_run = run - 1'b1;
          wr_en   = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    cmd_g = cmd;
    if (!exec) begin
      cmd_g.insert = 1'b0;
      cmd_g.pop    = 1'b0;
      cmd_g.remove = 1'b0;
    end
  end

  // sorted queue of task entries
  cpq_chain #(
    .NUM_CELLS (NUM_TASKS)
  ) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_g),
    .head_o (head)
  );

  // pending and running counts per task
  cpq_tbl #(
    .NUM_TASKS (NUM_TASKS),
    .RUN_W     (RunW)
  ) u_tbl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (accept),
    .rd_addr_i (rd_addr),
    .wr_en_i   (exec && wr_en),
    .wr_addr_i (addr_q),
    .wr_pend_i (new_pend),
    .wr_run_i  (new_run),
    .rd_pend_o (pend),
    .rd_run_o  (run)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      blocked_q   <= 1'b0;
      deferred_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        busy_q <= 1'b1;
      end else if (exec) begin
        busy_q <= 1'b0;
      end
      if (exec) begin
        blocked_q   <= blocked_d;
        deferred_q  <= deferred_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_i;
      addr_q <= rd_addr;
    end
    if (exec) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // an accepted transfer holds the input side for the next cycle
  a_stall_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not held after accepted transfer");

  // a result only appears out of the execute slot
  a_result_from_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(busy_q))
    else $error("result without executed item");

  // a queued head task always carries a nonzero pending count
  a_head_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && (item_q.op == cpq_pkg::OpDequeue) && head.vld |=> out_o.pending_out != '0)
    else $error("dequeued task with zero pending count");

endmodule

[hdl/cpq_cell.sv]
// one cell of the sorted queue chain: holds a single entry
// depends on cpq_pkg
module cpq_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cpq_pkg::cpq_cmd_t  cmd_i,
  input  cpq_pkg::cpq_entry_t left_i,
  input  logic               left_ge_i,
  input  cpq_pkg::cpq_entry_t right_i,
  input  logic               shift_i,
  output cpq_pkg::cpq_entry_t ent_o,
  output logic               ge_o,
  output logic               shift_o
);

  cpq_pkg::cpq_entry_t ent_q, ent_d;
  logic match;

  // entry stays ahead of a new one of lower or equal priority
  assign ge_o    = ent_q.vld && (ent_q.prio >= cmd_i.prio);
  assign match   = ent_q.vld && (ent_q.id == cmd_i.id);
  assign shift_o = shift_i | match;
  assign ent_o   = ent_q;

  always_comb begin
    ent_d = ent_q;
    if (cmd_i.insert) begin
      if (!ge_o) begin
        if (left_ge_i) begin
          ent_d.vld  = 1'b1;
          ent_d.id   = cmd_i.id;
          ent_d.prio = cmd_i.prio;
        end else begin
          ent_d = left_i;
        end
      end
    end else if (cmd_i.pop) begin
      ent_d = right_i;
    end else if (cmd_i.remove && shift_o) begin
      ent_d = right_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= '0;
    end else begin
      ent_q <= ent_d;
    end
  end

endmodule

[hdl/cpq_chain.sv]
// row of queue cells, head at cell zero, kept in priority order
// depends on cpq_pkg and cpq_cell
module cpq_chain #(
  parameter int unsigned NUM_CELLS = cpq_pkg::NumTasksDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cpq_pkg::cpq_cmd_t   cmd_i,
  output cpq_pkg::cpq_entry_t head_o
);

  cpq_pkg::cpq_entry_t ent   [NUM_CELLS];
  logic                ge    [NUM_CELLS];
  logic                shift [NUM_CELLS];

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    cpq_pkg::cpq_entry_t left, right;
    logic left_ge, shift_in;

    if (i == 0) begin : g_first
      assign left     = '0;
      assign left_ge  = 1'b1;
      assign shift_in = 1'b0;
    end else begin : g_mid
      assign left     = ent[i-1];
      assign left_ge  = ge[i-1];
      assign shift_in = shift[i-1];
    end

    if (i == NUM_CELLS - 1) begin : g_last
      assign right = '0;
    end else begin : g_inner
      assign right = ent[i+1];
    end

    cpq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd_i),
      .left_i    (left),
      .left_ge_i (left_ge),
      .right_i   (right),
      .shift_i   (shift_in),
      .ent_o     (ent[i]),
      .ge_o      (ge[i]),
      .shift_o   (shift[i])
    );
  end

  assign head_o = ent[0];

endmodule

[hdl/cpq_tbl.sv]
// per-task pending and running counts, one read and one write port
// depends on cpq_pkg
module cpq_tbl #(
  parameter int unsigned NUM_TASKS = cpq_pkg::NumTasksDef,
  parameter int unsigned RUN_W     = 3,
  localparam int unsigned IdxW     = $clog2(NUM_TASKS)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [IdxW-1:0]          rd_addr_i,
  input  logic                     wr_en_i,
  input  logic [IdxW-1:0]          wr_addr_i,
  input  logic [cpq_pkg::PendW-1:0] wr_pend_i,
  input  logic [RUN_W-1:0]         wr_run_i,
  output logic [cpq_pkg::PendW-1:0] rd_pend_o,
  output logic [RUN_W-1:0]         rd_run_o
);

  logic [cpq_pkg::PendW-1:0] pend_mem [NUM_TASKS];
  logic [RUN_W-1:0]          run_mem  [NUM_TASKS];
  logic [NUM_TASKS-1:0]      vld_q;
  logic [cpq_pkg::PendW-1:0] rd_pend_q;
  logic [RUN_W-1:0]          rd_run_q;
  logic                      rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      pend_mem[wr_addr_i] <= wr_pend_i;
      run_mem[wr_addr_i]  <= wr_run_i;
    end
    if (rd_en_i) begin
      rd_pend_q <= pend_mem[rd_addr_i];
      rd_run_q  <= run_mem[rd_addr_i];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_pend_o = rd_vld_q ? rd_pend_q : '0;
  assign rd_run_o  = rd_vld_q ? rd_run_q  : '0;

endmodule

[tb/cpq_checker.sv]
// checker for the coalescing priority task queue: watches both channels,
// predicts each result and compares it with what the block returns
// depends on cpq_pkg
module cpq_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  cpq_pkg::cpq_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  cpq_pkg::cpq_out_t out_data_i,
  output int unsigned       fail_count_o,
  output int unsigned       awaited_o
);

  timeunit 1ns;
  timeprecision 1ps;

  // predicted queue: entries head first, per-task counts and the block flags
  logic [cpq_pkg::TaskW-1:0] line_id   [cpq_pkg::NumTasksDef];
  logic [cpq_pkg::PrioW-1:0] line_prio [cpq_pkg::NumTasksDef];
  int unsigned               line_len;
  logic [cpq_pkg::PendW-1:0] pend_cnt  [cpq_pkg::NumTasksDef];
  logic [2:0]                run_cnt   [cpq_pkg::NumTasksDef];
  logic                      blocked_q;
  logic                      deferred_q;

  cpq_pkg::cpq_out_t awaited_results [$];
  cpq_pkg::cpq_out_t want;
  int unsigned       mismatches = 0;

  assign fail_count_o = mismatches;

  function automatic void drop_entry(input int unsigned pos);
    int unsigned k;
    for (k = pos; k + 1 < line_len; k++) begin
      line_id[k]   = line_id[k+1];
      line_prio[k] = line_prio[k+1];
    end
    line_len--;
  endfunction

  function automatic cpq_pkg::cpq_out_t apply_queue_op(input cpq_pkg::cpq_in_t item);
    cpq_pkg::cpq_out_t         r;
    int unsigned               pos;
    int unsigned               k;
    logic [cpq_pkg::TaskW-1:0] t;
    logic [cpq_pkg::TaskW-1:0] head;
    r = '0;
    t = item.task_id;
    case (item.op)
      cpq_pkg::OpEnqueue: begin
        if (pend_cnt[t] != '0) begin
          // already pending: only the count moves, saturating
          if (pend_cnt[t] != cpq_pkg::PendMax) pend_cnt[t]++;
          r.coalesced = 1'b1;
        end else begin
          pos = 0;
          while (pos < line_len && line_prio[pos] >= item.priority_req) pos++;
          for (k = line_len; k > pos; k--) begin
            line_id[k]   = line_id[k-1];
            line_prio[k] = line_prio[k-1];
          end
          line_id[pos]   = t;
          line_prio[pos] = item.priority_req;
          line_len++;
          pend_cnt[t] = cpq_pkg::PendW'(1);
          if (!blocked_q) r.notify = 1'b1;
          else deferred_q = 1'b1;
        end
      end
      cpq_pkg::OpDequeue: begin
        if (line_len == 0) begin
          r.empty_res = 1'b1;
        end else begin
          head = line_id[0];
          drop_entry(0);
          r.task_out    = head;
          r.pending_out = pend_cnt[head];
          pend_cnt[head] = '0;
          if (run_cnt[head] < cpq_pkg::MaxRunnersDef) run_cnt[head]++;
        end
      end
      cpq_pkg::OpCancel: begin
        r.pending_out = pend_cnt[t];
        if (pend_cnt[t] != '0) begin
          for (k = 0; k < line_len; k++) begin
            if (line_id[k] == t) begin
              drop_entry(k);
              break;
            end
          end
        end
        pend_cnt[t] = '0;
        r.busy_res = (run_cnt[t] != '0);
      end
      cpq_pkg::OpBlock: blocked_q = 1'b1;
      cpq_pkg::OpUnblock: begin
        blocked_q = 1'b0;
        if (deferred_q) begin
          deferred_q = 1'b0;
          r.notify   = 1'b1;
        end
      end
      cpq_pkg::OpComplete: if (run_cnt[t] != '0) run_cnt[t]--;
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < cpq_pkg::NumTasksDef; i++) begin
        line_id[i]   = '0;
        line_prio[i] = '0;
        pend_cnt[i]  = '0;
        run_cnt[i]   = '0;
      end
      line_len   = 0;
      blocked_q  = 1'b0;
      deferred_q = 1'b0;
      awaited_results.delete();
    end else begin
      // a result taken at this edge belongs to an earlier input, so compare first
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with no expectation waiting");
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          check_field("notify",      want.notify,      out_data_i.notify);
          check_field("task_out",    want.task_out,    out_data_i.task_out);
          check_field("pending_out", want.pending_out, out_data_i.pending_out);
          check_field("empty_res",   want.empty_res,   out_data_i.empty_res);
          check_field("busy_res",    want.busy_res,    out_data_i.busy_res);
          check_field("coalesced",   want.coalesced,   out_data_i.coalesced);
        end
      end
      if (in_valid_i && !in_stall_i) awaited_results.push_back(apply_queue_op(in_data_i));
    end
    awaited_o = awaited_results.size();
  end

endmodule

[tb/tb.sv]
// top of the coalescing priority task queue testbench: clock, reset, stimulus,
// receiver stalls and the verdict
// depends on cpq_pkg, coalescing_priority_task_queue and cpq_checker
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  // op codes the block leaves unused
  localparam logic [cpq_pkg::OpW-1:0] OpSpareLo = 3'd6;
  localparam logic [cpq_pkg::OpW-1:0] OpSpareHi = 3'd7;

  localparam int unsigned RandomItems = 600;
  localparam int unsigned HoldCycles  = 200;
  localparam int unsigned SettleCycles = 8;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid;
  logic              in_stall;
  cpq_pkg::cpq_in_t  in_data;
  logic              out_valid;
  logic              out_stall;
  cpq_pkg::cpq_out_t out_data;

  int unsigned fail_count;
  int unsigned awaited;

  // quiet: no idling on either side; hold_arm asks the receiver for one long hold-off
  logic quiet;
  logic hold_arm;
  logic hold_done;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  coalescing_priority_task_queue dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_i       (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_o      (out_data)
  );

  cpq_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .fail_count_o(fail_count),
    .awaited_o   (awaited)
  );

  // idle lengths: mostly none or short, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // mostly well-formed traffic: enqueues and dequeues dominate, completes and
  // cancels aim at a small set of hot tasks so they hit queued and running ones
  function automatic cpq_pkg::cpq_in_t random_item();
    cpq_pkg::cpq_in_t it;
    int unsigned      roll;
    roll = $urandom_range(0, 99);
    if (roll < 36)      it.op = cpq_pkg::OpEnqueue;
    else if (roll < 60) it.op = cpq_pkg::OpDequeue;
    else if (roll < 70) it.op = cpq_pkg::OpCancel;
    else if (roll < 82) it.op = cpq_pkg::OpComplete;
    else if (roll < 88) it.op = cpq_pkg::OpBlock;
    else if (roll < 94) it.op = cpq_pkg::OpUnblock;
    else                it.op = cpq_pkg::OpW'($urandom_range(0, 7));
    if ($urandom_range(0, 9) < 6) it.task_id = cpq_pkg::TaskW'($urandom_range(0, 5));
    else                          it.task_id = cpq_pkg::TaskW'($urandom_range(0, 31));
    // a few priority levels so that ties occur often
    if ($urandom_range(0, 9) < 4) begin
      it.priority_req = cpq_pkg::PrioW'($urandom_range(0, 3) * 85);
    end else begin
      it.priority_req = cpq_pkg::PrioW'($urandom_range(0, 255));
    end
    return it;
  endfunction

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic offer(input cpq_pkg::cpq_in_t item);
    int unsigned gap;
    gap = quiet ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
  endtask

  task automatic send_op(input logic [cpq_pkg::OpW-1:0] op, input int unsigned id,
                         input int unsigned prio);
    cpq_pkg::cpq_in_t item;
    item.op           = op;
    item.task_id      = cpq_pkg::TaskW'(id);
    item.priority_req = cpq_pkg::PrioW'(prio);
    offer(item);
  endtask

  // stop offering until every awaited result has been taken
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (awaited != 0) @(negedge clk_i);
  endtask

  // receiver: random stalls, one long hold-off on request, nothing while quiet
  initial begin : receiver
    out_stall = 1'b0;
    hold_done = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (hold_arm && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
        hold_done = 1'b1;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat (pick_gap() + 1) @(negedge clk_i);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
  end

  initial begin : stimulus
    in_valid = 1'b0;
    in_data  = '0;
    quiet    = 1'b0;
    hold_arm = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty and idle corner cases first
    send_op(cpq_pkg::OpDequeue, 0, 0);          // empty dequeue
    send_op(cpq_pkg::OpComplete, 0, 0);         // complete with no running mark
    send_op(cpq_pkg::OpCancel, 31, 255);        // cancel of a task that is not queued
    send_op(cpq_pkg::OpEnqueue, 5, 0);
    send_op(cpq_pkg::OpEnqueue, 6, 255);
    send_op(cpq_pkg::OpEnqueue, 7, 255);        // equal priority goes behind task 6
    send_op(cpq_pkg::OpEnqueue, 5, 255);        // coalesces, new priority ignored
    send_op(cpq_pkg::OpBlock, 0, 0);
    send_op(cpq_pkg::OpBlock, 0, 0);            // repeated block
    send_op(cpq_pkg::OpEnqueue, 31, 128);       // notify deferred while blocked
    send_op(cpq_pkg::OpUnblock, 0, 0);          // releases the deferred notify
    send_op(cpq_pkg::OpUnblock, 0, 0);          // nothing deferred this time
    send_op(cpq_pkg::OpDequeue, 0, 0);          // task 6
    send_op(cpq_pkg::OpCancel, 6, 0);           // not queued but running
    send_op(OpSpareLo, 31, 255);
    send_op(OpSpareHi, 31, 255);
    send_op(cpq_pkg::OpDequeue, 0, 0);          // task 7
    send_op(cpq_pkg::OpDequeue, 0, 0);          // task 31
    send_op(cpq_pkg::OpDequeue, 0, 0);          // task 5 with a count of two
    send_op(cpq_pkg::OpComplete, 5, 0);

    // running marks at the top: one more dequeue than the marks can hold
    repeat (cpq_pkg::MaxRunnersDef + 1) begin
      send_op(cpq_pkg::OpEnqueue, 9, $urandom_range(0, 255));
      send_op(cpq_pkg::OpDequeue, 0, 0);
    end
    send_op(cpq_pkg::OpCancel, 9, 0);

    for (int unsigned n = 0; n < RandomItems; n++) begin
      // long receiver hold-off while the sender keeps offering
      if (n == 200) hold_arm = 1'b1;
      // sender pause until the block has handed back everything
      if (n == 400) wait_for_results();
      // a stretch with no idling on either side
      if (n == 450) quiet = 1'b1;
      if (n == 520) quiet = 1'b0;
      offer(random_item());
    end

    wait_for_results();
    repeat (SettleCycles) @(negedge clk_i);
    if (fail_count == 0 && awaited == 0) begin
      $display("coalescing_priority_task_queue regression: pass");
    end else begin
      $display("coalescing_priority_task_queue regression: fail");
    end
    $finish;
  end

  // watchdog, several times the slowest legal run
  initial begin : watchdog
    #2000000;
    $display("coalescing_priority_task_queue regression: fail");
    $finish;
  end

endmodule
